FILE: hdl/fcc_pkg.sv
// fcc_pkg: shared types and constants for the frustum cull classifier
// no dependencies; imported by frustum_cull_classify_unit and its testbench

package fcc_pkg;

   localparam int PLANE_COUNT    = 6;
   localparam int COORD_BITS     = 16;
   localparam int REG_PLANES     = 6;
   localparam int AXES           = 3;
   localparam int NORM_BITS      = 16;
   localparam int OFFSET_BITS    = 16;
   localparam int FRAC_SHIFT     = 14;
   localparam int PLANE_BITS     = 64;
   localparam int EPS_BITS       = 16;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int SIDE_BITS      = 2;

   localparam int PROD_BITS = NORM_BITS + COORD_BITS;
   localparam int OFFS_BITS = OFFSET_BITS + FRAC_SHIFT;
   localparam int DIST_BITS = ((PROD_BITS > OFFS_BITS) ? PROD_BITS : OFFS_BITS) + 2;

   localparam logic [EPS_BITS-1:0]       EPS_RESET   = EPS_BITS'(42);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EPSILON = CSR_INDEX_BITS'(REG_PLANES);

   typedef enum logic [SIDE_BITS-1:0] {
      SIDE_INSIDE  = 2'd0,
      SIDE_OUTSIDE = 2'd1,
      SIDE_OVERLAP = 2'd2
   } side_type;

   // packed plane layout as written through the csr port
   typedef struct packed {
      logic signed [OFFSET_BITS-1:0] d;
      logic signed [NORM_BITS-1:0]   nz;
      logic signed [NORM_BITS-1:0]   ny;
      logic signed [NORM_BITS-1:0]   nx;
   } plane_type;

endpackage

FILE: hdl/frustum_cull_classify_unit.sv
// frustum_cull_classify_unit: box / sphere classification against the view planes
// depends on fcc_pkg (types, widths, register indexes)
//
//   port group  direction  handshake                  payload
//   req_        in         start high, busy low       op, min/max x y z, radius
//   rsp_        out        rsp_strobe for one cycle   side
//   csr_        in         csr_we                     csr_index, csr_wdata
//
// one item per cycle; busy stays low, so start is taken at every edge
// an accepted item shows on rsp_ once it has passed every register of the pipeline
// pipeline: input register, plane products, corner extremes, result register
// synchronous reset clears the planes to zero and epsilon to its default
// the receiver cannot stall; results are never held

module frustum_cull_classify_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_op,
   input  logic signed [fcc_pkg::COORD_BITS-1:0] req_min_x,
   input  logic signed [fcc_pkg::COORD_BITS-1:0] req_min_y,
   input  logic signed [fcc_pkg::COORD_BITS-1:0] req_min_z,
   input  logic signed [fcc_pkg::COORD_BITS-1:0] req_max_x,
   input  logic signed [fcc_pkg::COORD_BITS-1:0] req_max_y,
   input  logic signed [fcc_pkg::COORD_BITS-1:0] req_max_z,
   input  logic        [fcc_pkg::COORD_BITS-2:0] req_radius,
   output logic                                  rsp_strobe,
   output logic        [fcc_pkg::SIDE_BITS-1:0]  rsp_side,
   input  logic                                  csr_we,
   input  logic [fcc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [fcc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   import fcc_pkg::*;

   // configuration registers
   plane_type             plane_ff [REG_PLANES];
   logic [EPS_BITS-1:0]   eps_ff;
   plane_type             plane_eff [PLANE_COUNT];
   logic signed [NORM_BITS-1:0] norm [PLANE_COUNT][AXES];

   // input stage
   logic                         accept;
   logic                         vld0_ff;
   logic                         op0_ff;
   logic signed [COORD_BITS-1:0] lo0_ff [AXES];
   logic signed [COORD_BITS-1:0] hi0_ff [AXES];
   logic [COORD_BITS-2:0]        rad0_ff;

   // product stage
   logic                         vld1_ff;
   logic                         op1_ff;
   logic [COORD_BITS-2:0]        rad1_ff;
   logic signed [PROD_BITS-1:0]  plo1_ff [PLANE_COUNT][AXES];
   logic signed [PROD_BITS-1:0]  phi1_ff [PLANE_COUNT][AXES];

   // extreme distance stage
   logic                         vld2_ff;
   logic                         op2_ff;
   logic [COORD_BITS-2:0]        rad2_ff;
   logic signed [DIST_BITS-1:0]  dmax2_ff [PLANE_COUNT];
   logic signed [DIST_BITS-1:0]  dmin2_ff [PLANE_COUNT];
   logic signed [DIST_BITS-1:0]  dmax2_in [PLANE_COUNT];
   logic signed [DIST_BITS-1:0]  dmin2_in [PLANE_COUNT];

   // result stage
   logic signed [DIST_BITS-1:0]  thr;
   logic                         any_out;
   logic                         any_ovl;
   side_type                     side_in;
   logic                         strobe_ff;
   side_type                     side_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         for (int i = 0; i < REG_PLANES; i++) begin
            if (csr_index == CSR_INDEX_BITS'(i)) begin
               plane_ff[i] <= plane_type'(csr_wdata[PLANE_BITS-1:0]);
            end
         end
         if (csr_index == CSR_EPSILON) begin
            eps_ff <= csr_wdata[EPS_BITS-1:0];
         end
      end
   end

   // planes without a register stay at zero
   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      if (p < REG_PLANES) begin : g_reg
         assign plane_eff[p] = plane_ff[p];
      end else begin : g_zero
         assign plane_eff[p] = '0;
      end
      assign norm[p][0] = plane_eff[p].nx;
      assign norm[p][1] = plane_eff[p].ny;
      assign norm[p][2] = plane_eff[p].nz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         vld0_ff <= accept;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         strobe_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op0_ff    <= req_op;
         lo0_ff[0] <= req_min_x;
         lo0_ff[1] <= req_min_y;
         lo0_ff[2] <= req_min_z;
         hi0_ff[0] <= req_max_x;
         hi0_ff[1] <= req_max_y;
         hi0_ff[2] <= req_max_z;
         rad0_ff   <= req_radius;
      end
   end

   // one product per normal component and box bound
   always_ff @(posedge clock) begin
      op1_ff  <= op0_ff;
      rad1_ff <= rad0_ff;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         for (int a = 0; a < AXES; a++) begin
            plo1_ff[p][a] <= PROD_BITS'(norm[p][a] * lo0_ff[a]);
            phi1_ff[p][a] <= PROD_BITS'(norm[p][a] * hi0_ff[a]);
         end
      end
   end

   // largest and smallest corner distance; a sphere uses its center for both
   always_comb begin
      logic signed [DIST_BITS-1:0] big;
      logic signed [DIST_BITS-1:0] low;
      logic signed [DIST_BITS-1:0] offs;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         offs = DIST_BITS'(plane_eff[p].d) <<< FRAC_SHIFT;
         dmax2_in[p] = -offs;
         dmin2_in[p] = -offs;
         for (int a = 0; a < AXES; a++) begin
            if (op1_ff || (plo1_ff[p][a] >= phi1_ff[p][a])) begin
               big = DIST_BITS'(plo1_ff[p][a]);
            end else begin
               big = DIST_BITS'(phi1_ff[p][a]);
            end
            if (op1_ff || (plo1_ff[p][a] <= phi1_ff[p][a])) begin
               low = DIST_BITS'(plo1_ff[p][a]);
            end else begin
               low = DIST_BITS'(phi1_ff[p][a]);
            end
            dmax2_in[p] = dmax2_in[p] + big;
            dmin2_in[p] = dmin2_in[p] + low;
         end
      end
   end

   always_ff @(posedge clock) begin
      op2_ff  <= op1_ff;
      rad2_ff <= rad1_ff;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         dmax2_ff[p] <= dmax2_in[p];
         dmin2_ff[p] <= dmin2_in[p];
      end
   end

   // per plane side, then outside beats overlapping beats inside
   always_comb begin
      logic above;
      logic below;
      if (op2_ff) begin
         thr = signed'(DIST_BITS'({rad2_ff, {FRAC_SHIFT{1'b0}}}));
      end else begin
         thr = signed'(DIST_BITS'(eps_ff));
      end
      any_out = 1'b0;
      any_ovl = 1'b0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         above = dmax2_ff[p] > thr;
         below = dmin2_ff[p] < -thr;
         if (op2_ff) begin
            if (above) begin
               any_out = 1'b1;
            end else if (!below) begin
               any_ovl = 1'b1;
            end
         end else begin
            if (above && below) begin
               any_ovl = 1'b1;
            end else if (!below) begin
               any_out = 1'b1;
            end
         end
      end
      if (any_out) begin
         side_in = SIDE_OUTSIDE;
      end else if (any_ovl) begin
         side_in = SIDE_OVERLAP;
      end else begin
         side_in = SIDE_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_side   = side_ff;

   // every accepted item leaves on rsp_strobe
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("accepted item produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 4))
      else $error("result without an accepted item");

   a_sphere_point: assert property (@(posedge clock) disable iff (reset)
      (vld2_ff && op2_ff) |-> (dmax2_ff[0] == dmin2_ff[0]))
      else $error("sphere center distance split between extremes");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      vld2_ff |-> (dmax2_ff[0] >= dmin2_ff[0]))
      else $error("corner extremes out of order");

endmodule

FILE: tb/tb_frustum_cull_classify_unit.sv
`timescale 1ns / 1ps
// tb_frustum_cull_classify_unit: self-checking bench for the frustum cull classifier
// depends on fcc_pkg and frustum_cull_classify_unit; predicts the side of every
// box and sphere item against the written planes and checks each rsp_ strobe

module tb_frustum_cull_classify_unit;
   import fcc_pkg::*;

   localparam int  CLK_HALF       = 6;
   localparam int  TIMEOUT_CYCLES = 100000;
   localparam int  DRAIN_LIMIT    = 2000;
   localparam int  LATENCY_SLACK  = 8;
   localparam int  PHASE_ITEMS    = 130;
   localparam int  PHASES         = 8;
   localparam int  IDLE_PERCENT   = 7;
   localparam logic OP_BOX        = 1'b0;
   localparam logic OP_SPHERE     = 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = CSR_INDEX_BITS'(7);

   typedef struct packed {
      logic                         op;
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] min_z;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] max_y;
      logic signed [COORD_BITS-1:0] max_z;
      logic        [COORD_BITS-2:0] radius;
   } volume_type;

   class cull_side_checker;
      plane_type           planes [PLANE_COUNT];
      logic [EPS_BITS-1:0] eps;
      side_type            expected_sides [$];
      int                  mismatches;

      function new();
         foreach (planes[i]) planes[i] = '0;
         eps = EPS_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx < REG_PLANES) begin
            planes[idx] = plane_type'(data[PLANE_BITS-1:0]);
         end else if (idx == CSR_EPSILON) begin
            eps = data[EPS_BITS-1:0];
         end
      endfunction

      function longint plane_distance(plane_type p, longint x, longint y, longint z);
         longint nx, ny, nz, d;
         nx = $signed(p.nx);
         ny = $signed(p.ny);
         nz = $signed(p.nz);
         d  = $signed(p.d);
         return nx * x + ny * y + nz * z - d * (longint'(1) <<< FRAC_SHIFT);
      endfunction

      function side_type box_vs_plane(plane_type p, volume_type v);
         longint x, y, z, dval, tol;
         bit above, below;
         above = 1'b0;
         below = 1'b0;
         tol = longint'(eps);
         for (int k = 0; k < 8; k++) begin
            x = k[0] ? longint'($signed(v.max_x)) : longint'($signed(v.min_x));
            y = k[1] ? longint'($signed(v.max_y)) : longint'($signed(v.min_y));
            z = k[2] ? longint'($signed(v.max_z)) : longint'($signed(v.min_z));
            dval = plane_distance(p, x, y, z);
            if (dval > tol) above = 1'b1;
            else if (dval < -tol) below = 1'b1;
         end
         if (above && below) return SIDE_OVERLAP;
         if (below) return SIDE_INSIDE;
         return SIDE_OUTSIDE;
      endfunction

      function side_type sphere_vs_plane(plane_type p, volume_type v);
         longint dval, rr;
         rr = longint'(v.radius) <<< FRAC_SHIFT;
         dval = plane_distance(p, $signed(v.min_x), $signed(v.min_y), $signed(v.min_z));
         if (dval > rr) return SIDE_OUTSIDE;
         if (dval < -rr) return SIDE_INSIDE;
         return SIDE_OVERLAP;
      endfunction

      function side_type classify(volume_type v);
         side_type s;
         bit overlap;
         overlap = 1'b0;
         for (int i = 0; i < PLANE_COUNT; i++) begin
            if (v.op == OP_SPHERE) s = sphere_vs_plane(planes[i], v);
            else s = box_vs_plane(planes[i], v);
            if (s == SIDE_OUTSIDE) return SIDE_OUTSIDE;
            if (s == SIDE_OVERLAP) overlap = 1'b1;
         end
         if (overlap) return SIDE_OVERLAP;
         return SIDE_INSIDE;
      endfunction

      function void note_volume(volume_type v);
         expected_sides.push_back(classify(v));
      endfunction

      function int pending();
         return expected_sides.size();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_side(logic [SIDE_BITS-1:0] got);
         side_type want;
         if (expected_sides.size() == 0) begin
            report_mismatch($sformatf("side %0d with no item pending", got));
            return;
         end
         want = expected_sides.pop_front();
         if (got !== want)
            report_mismatch($sformatf("side got %0d expected %0d (%s)", got, want, want.name()));
      endtask
   endclass

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         start     = 1'b0;
   logic                         busy;
   logic                         req_op    = OP_BOX;
   logic signed [COORD_BITS-1:0] req_min_x = '0;
   logic signed [COORD_BITS-1:0] req_min_y = '0;
   logic signed [COORD_BITS-1:0] req_min_z = '0;
   logic signed [COORD_BITS-1:0] req_max_x = '0;
   logic signed [COORD_BITS-1:0] req_max_y = '0;
   logic signed [COORD_BITS-1:0] req_max_z = '0;
   logic        [COORD_BITS-2:0] req_radius = '0;
   logic                         rsp_strobe;
   logic        [SIDE_BITS-1:0]  rsp_side;
   logic                         csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_wdata = '0;

   cull_side_checker cull_chk;

   frustum_cull_classify_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_min_x  (req_min_x),
      .req_min_y  (req_min_y),
      .req_min_z  (req_min_z),
      .req_max_x  (req_max_x),
      .req_max_y  (req_max_y),
      .req_max_z  (req_max_z),
      .req_radius (req_radius),
      .rsp_strobe (rsp_strobe),
      .rsp_side   (rsp_side),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) cull_chk.check_side(rsp_side);
   end

   function automatic plane_type make_plane(int nx, int ny, int nz, int d);
      plane_type p;
      p.nx = NORM_BITS'(nx);
      p.ny = NORM_BITS'(ny);
      p.nz = NORM_BITS'(nz);
      p.d  = OFFSET_BITS'(d);
      return p;
   endfunction

   // roughly axis-aligned face, normal pointing out of the view volume
   function automatic plane_type face_plane(int k);
      int n [AXES];
      int axis, sgn;
      axis = k / 2;
      sgn = (k % 2 == 1) ? -1 : 1;
      for (int j = 0; j < AXES; j++) n[j] = int'($urandom_range(0, 4096)) - 2048;
      n[axis] = sgn * (16384 - int'($urandom_range(0, 4096)));
      return make_plane(n[0], n[1], n[2], int'($urandom_range(256, 4096)));
   endfunction

   function automatic volume_type make_volume(logic op, int mnx, int mny, int mnz,
                                              int mxx, int mxy, int mxz, int r);
      volume_type v;
      v.op = op;
      v.min_x = COORD_BITS'(mnx);
      v.min_y = COORD_BITS'(mny);
      v.min_z = COORD_BITS'(mnz);
      v.max_x = COORD_BITS'(mxx);
      v.max_y = COORD_BITS'(mxy);
      v.max_z = COORD_BITS'(mxz);
      v.radius = (COORD_BITS-1)'(r);
      return v;
   endfunction

   function automatic volume_type random_volume();
      volume_type v;
      logic [127:0] raw;
      int c [AXES];
      int h [AXES];
      int t;
      if ($urandom_range(0, 99) < 20) begin
         raw = {$urandom, $urandom, $urandom, $urandom};
         v = raw[$bits(volume_type)-1:0];
      end else begin
         for (int j = 0; j < AXES; j++) begin
            c[j] = int'($urandom_range(0, 8192)) - 4096;
            h[j] = int'($urandom_range(0, 1536));
         end
         v = make_volume(1'($urandom_range(0, 1)), c[0] - h[0], c[1] - h[1], c[2] - h[2],
                         c[0] + h[0], c[1] + h[1], c[2] + h[2],
                         int'($urandom_range(0, 1536)));
         if ($urandom_range(0, 19) == 0) begin
            t = v.min_x;
            v.min_x = v.max_x;
            v.max_x = COORD_BITS'(t);
         end
      end
      return v;
   endfunction

   task automatic send_volume(volume_type v);
      @(negedge clock);
      start      = 1'b1;
      req_op     = v.op;
      req_min_x  = v.min_x;
      req_min_y  = v.min_y;
      req_min_z  = v.min_z;
      req_max_x  = v.max_x;
      req_max_y  = v.max_y;
      req_max_z  = v.max_z;
      req_radius = v.radius;
      do @(posedge clock); while (busy !== 1'b0);
      cull_chk.note_volume(v);
   endtask

   task automatic maybe_idle(bit allow);
      if (allow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      start = 1'b0;
      while (cull_chk.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      cull_chk.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      logic [EPS_BITS-1:0] eps_val;
      cull_chk = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset planes: every box outside, every sphere overlapping
      send_volume(make_volume(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
      send_volume(make_volume(OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0));
      send_volume(make_volume(OP_SPHERE, -32768, 0, 0, 0, 0, 0, 32767));
      settle();

      // cube of half size 8.0 around the origin
      for (int k = 0; k < REG_PLANES; k++)
         csr_write(CSR_INDEX_BITS'(k),
                   make_plane((k / 2 == 0) ? ((k % 2 == 1) ? -16384 : 16384) : 0,
                              (k / 2 == 1) ? ((k % 2 == 1) ? -16384 : 16384) : 0,
                              (k / 2 == 2) ? ((k % 2 == 1) ? -16384 : 16384) : 0, 2048));
      send_volume(make_volume(OP_BOX, -256, -256, -256, 256, 256, 256, 0));
      send_volume(make_volume(OP_BOX, 5120, -256, -256, 7680, 256, 256, 0));
      send_volume(make_volume(OP_BOX, 0, -256, -256, 5120, 256, 256, 0));
      // flat box lying in the +x plane
      send_volume(make_volume(OP_BOX, 2048, -256, -256, 2048, 256, 256, 0));
      // inverted boxes
      send_volume(make_volume(OP_BOX, 1024, 1024, 1024, -1024, -1024, -1024, 0));
      send_volume(make_volume(OP_BOX, 5120, 256, 256, 0, -256, -256, 0));
      send_volume(make_volume(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
      send_volume(make_volume(OP_SPHERE, 0, 0, 0, 32767, -32768, 32767, 256));
      send_volume(make_volume(OP_SPHERE, 5120, 0, 0, 0, 0, 0, 256));
      send_volume(make_volume(OP_SPHERE, 1792, 0, 0, 0, 0, 0, 512));
      // spheres touching the +x plane from either side
      send_volume(make_volume(OP_SPHERE, 2304, 0, 0, 0, 0, 0, 256));
      send_volume(make_volume(OP_SPHERE, 1792, 0, 0, 0, 0, 0, 256));
      settle();

      // extreme planes, zero normals, widest tolerance, ignored register index
      for (int k = 0; k < REG_PLANES; k++)
         csr_write(CSR_INDEX_BITS'(k), {CSR_DATA_BITS{1'b1}});
      csr_write(CSR_EPSILON, CSR_DATA_BITS'(16'hFFFF));
      csr_write(CSR_UNUSED, {$urandom, $urandom});
      send_volume(make_volume(OP_BOX, -256, -256, -256, 256, 256, 256, 0));
      send_volume(make_volume(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
      send_volume(make_volume(OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767));
      settle();
      csr_write(CSR_INDEX_BITS'(0), make_plane(-32768, 32767, -32768, 32767));
      csr_write(CSR_INDEX_BITS'(1), make_plane(0, 0, 0, 32767));
      csr_write(CSR_INDEX_BITS'(2), make_plane(32767, -32768, 32767, -32768));
      csr_write(CSR_INDEX_BITS'(3), make_plane(0, 0, 0, 256));
      csr_write(CSR_EPSILON, '0);
      send_volume(make_volume(OP_BOX, 32767, 32767, 32767, 32767, 32767, 32767, 0));
      send_volume(make_volume(OP_BOX, -32768, 32767, -32768, -32768, 32767, -32768, 0));
      send_volume(make_volume(OP_SPHERE, 0, 0, 0, 0, 0, 0, 32767));
      settle();

      for (int p = 0; p < PHASES; p++) begin
         for (int k = 0; k < REG_PLANES; k++) begin
            if (p == 2) csr_write(CSR_INDEX_BITS'(k), {$urandom, $urandom});
            else if (p == 5 && k == 3)
               csr_write(CSR_INDEX_BITS'(k),
                         make_plane(0, 0, 0, int'($urandom_range(0, 65535))));
            else csr_write(CSR_INDEX_BITS'(k), face_plane(k));
         end
         if (p == 0) eps_val = '0;
         else if (p == PHASES - 1) eps_val = '1;
         else if (p % 2 == 1) eps_val = EPS_BITS'($urandom_range(0, 512));
         else eps_val = EPS_BITS'($urandom);
         csr_write(CSR_EPSILON, CSR_DATA_BITS'(eps_val));
         if (p == 4) csr_write(CSR_UNUSED, {$urandom, $urandom});
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            maybe_idle(p != 3);
            send_volume(random_volume());
         end
         settle();
      end

      if (cull_chk.pending() != 0)
         cull_chk.report_mismatch($sformatf("%0d items never answered", cull_chk.pending()));
      if (cull_chk.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("timeout with %0d items pending", cull_chk.pending());
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: files.f
hdl/fcc_pkg.sv
hdl/frustum_cull_classify_unit.sv
tb/tb_frustum_cull_classify_unit.sv
